>>> src/kpac_pkg.sv
// ----------------------------------------------------------------------------
// kpac_pkg
// Shared types and constants of the keypad PIN alarm controller.
// ----------------------------------------------------------------------------
package kpac_pkg;

    localparam int PIN_DIGITS_DEF = 4;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0]  KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0]  KEY_STAR      = 4'd10;
    localparam logic [3:0]  KEY_HASH      = 4'd11;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    localparam logic [15:0] ARM_DELAY_RST    = 16'd50000;
    localparam logic [15:0] BUZZER_DELAY_RST = 16'd50000;
    localparam logic [2:0]  MAX_ATTEMPTS_RST = 3'd3;

    typedef enum logic [2:0] {
        MODE_DISARMED = 3'd0,
        MODE_OLDPIN   = 3'd1,
        MODE_NEWPIN   = 3'd2,
        MODE_CONFIRM  = 3'd3,
        MODE_ARMING   = 3'd4,
        MODE_ARMED    = 3'd5,
        MODE_ENTRY    = 3'd6,
        MODE_LOCKED   = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_MOTION = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PIN_NONE = 2'd0,
        PIN_OK   = 2'd1,
        PIN_BAD  = 2'd2
    } t_pin_res;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ARM_DELAY    = 2'd0,
        CFG_BUZZER_DELAY = 2'd1,
        CFG_MAX_ATTEMPTS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] arm_delay;
        logic [15:0] buzzer_delay;
        logic [2:0]  max_attempts;
    } t_cfg;

    // Packed from the top down, so mode sits in the lowest bits.
    typedef struct packed {
        t_pin_res   pin_result;
        logic [2:0] attempts_left;
        logic [2:0] digits_entered;
        logic       buzzer;
        t_mode      mode;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

>>> src/kpac_engine.sv
// ----------------------------------------------------------------------------
// kpac_engine
// Alarm state, PIN store and digit buffer; works out one result per item.
// ----------------------------------------------------------------------------
module kpac_engine #(
    parameter int PIN_DIGITS = kpac_pkg::PIN_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [1:0]        i_cmd,
    input  logic [3:0]        i_key,
    input  kpac_pkg::t_cfg    i_cfg,
    output kpac_pkg::t_result o_result
);
    import kpac_pkg::*;

    localparam int CW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

    t_mode                      r_mode, n_mode;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [15:0]                r_tick, n_tick;
    logic [2:0]                 r_tries, n_tries;
    logic                       r_buzz, n_buzz;
    logic [PIN_DIGITS-1:0][3:0] r_buf, n_buf;
    logic [PIN_DIGITS-1:0][3:0] r_pin, n_pin;

    logic [PIN_DIGITS-1:0][3:0] buf_cand;
    t_pin_res                   res;
    logic                       is_key, is_tick, take, full, match;
    logic [CW-1:0]              cnt_take;
    logic [15:0]                tick_inc;
    logic [2:0]                 tries_dec;

    always_comb begin
        is_key   = (i_cmd == CMD_KEY);
        is_tick  = (i_cmd == CMD_TICK);
        take     = is_key && (i_key <= KEY_DIGIT_MAX);
        buf_cand = r_buf;
        buf_cand[r_cnt] = i_key;
        full     = (r_cnt == CW'(PIN_DIGITS - 1));
        cnt_take = full ? '0 : r_cnt + CW'(1);
        match    = (buf_cand == r_pin);
        tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 16'd1;
        tries_dec = (r_tries != 3'd0) ? r_tries - 3'd1 : 3'd0;

        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_tick  = r_tick;
        n_tries = r_tries;
        n_buzz  = r_buzz;
        n_buf   = r_buf;
        n_pin   = r_pin;
        res     = PIN_NONE;

        case (r_mode)
            MODE_DISARMED: begin
                if (is_key && i_key == KEY_STAR) begin
                    n_mode = MODE_ARMING;
                    n_tick = '0;
                end else if (is_key && i_key == KEY_HASH) begin
                    n_mode = MODE_OLDPIN;
                    n_cnt  = '0;
                end
            end
            MODE_OLDPIN: begin
                if (take) begin
                    n_buf = buf_cand;
                    n_cnt = cnt_take;
                    if (full) begin
                        n_mode = match ? MODE_NEWPIN : MODE_DISARMED;
                        res    = match ? PIN_OK : PIN_BAD;
                    end
                end
            end
            MODE_NEWPIN: begin
                if (take) begin
                    n_buf = buf_cand;
                    n_cnt = cnt_take;
                    if (full) begin
                        n_mode = MODE_CONFIRM;
                    end
                end
            end
            MODE_CONFIRM: begin
                // Any key leaves; only hash commits the new PIN.
                if (is_key) begin
                    if (i_key == KEY_HASH) begin
                        n_pin = r_buf;
                    end
                    n_mode = MODE_DISARMED;
                end
            end
            MODE_ARMING: begin
                if (is_tick) begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_cfg.arm_delay) begin
                        n_mode = MODE_ARMED;
                        n_tick = '0;
                    end
                end
            end
            MODE_ARMED: begin
                if (i_cmd == CMD_MOTION) begin
                    n_mode  = MODE_ENTRY;
                    n_tick  = '0;
                    n_cnt   = '0;
                    n_tries = (i_cfg.max_attempts == 3'd0) ? 3'd1 : i_cfg.max_attempts;
                end
            end
            MODE_ENTRY: begin
                if (take) begin
                    n_buf = buf_cand;
                    n_cnt = cnt_take;
                    if (full) begin
                        if (match) begin
                            n_mode  = MODE_DISARMED;
                            n_buzz  = 1'b0;
                            n_tick  = '0;
                            n_tries = '0;
                            res     = PIN_OK;
                        end else begin
                            res     = PIN_BAD;
                            n_tries = tries_dec;
                            if (tries_dec == 3'd0) begin
                                n_mode = MODE_LOCKED;
                            end
                        end
                    end
                end else if (is_tick && !r_buzz) begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_cfg.buzzer_delay) begin
                        n_buzz = 1'b1;
                    end
                end
            end
            default: begin
                // Locked: the buzzer delay keeps running.
                if (is_tick && !r_buzz) begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_cfg.buzzer_delay) begin
                        n_buzz = 1'b1;
                    end
                end
            end
        endcase

        o_result.mode           = n_mode;
        o_result.buzzer         = n_buzz;
        o_result.digits_entered = 3'(n_cnt);
        o_result.attempts_left  = n_tries;
        o_result.pin_result     = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DISARMED;
            r_cnt   <= '0;
            r_tick  <= '0;
            r_tries <= '0;
            r_buzz  <= 1'b0;
            for (int i = 0; i < PIN_DIGITS; i++) begin
                r_pin[i] <= 4'(i + 1);
            end
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_tick  <= n_tick;
            r_tries <= n_tries;
            r_buzz  <= n_buzz;
            r_pin   <= n_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_buf <= n_buf;
        end
    end

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_OLDPIN && r_mode != MODE_NEWPIN && r_mode != MODE_ENTRY)
        |-> r_cnt == '0)
        else $error("digit count held outside PIN collection");

    a_tries_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_ENTRY && r_mode != MODE_LOCKED) |-> r_tries == 3'd0)
        else $error("attempts left outside entry or lockout");

    a_buzz_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzz |-> (r_mode == MODE_ENTRY || r_mode == MODE_LOCKED))
        else $error("buzzer on outside entry or lockout");

    a_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_LOCKED |=> r_mode == MODE_LOCKED)
        else $error("left lockout without reset");

endmodule

>>> src/kpac_out_queue.sv
// ----------------------------------------------------------------------------
// kpac_out_queue
// Two-entry result buffer, so a waiting result does not stall the input.
// ----------------------------------------------------------------------------
module kpac_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kpac_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output kpac_pkg::t_result o_data
);
    import kpac_pkg::*;

    t_result    r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("item pushed into a full result buffer");

    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !i_push) |=> r_cnt == 2'd0)
        else $error("result appeared without a push");

endmodule

>>> src/keypad_pin_alarm_controller_core.sv
// ----------------------------------------------------------------------------
// keypad_pin_alarm_controller_core
// Keypad PIN alarm: arming delay, PIN change, motion entry with buzzer delay
// and lockout after too many wrong PINs.
//
//  Channel   Direction  Signals                       Contents
//  s         in         i_s_tvalid/o_s_tready         tuser: command, tdata: key
//  m         out        o_m_tvalid/i_m_tready         tdata: one result per item
//  cfg       in         i_cfg_we/i_cfg_addr/wdata     delay and attempt registers
//
// Every item gives exactly one result; an item waits in the input register,
// its result is written into a two-entry output buffer, and the block
// sustains one item per cycle unless the output buffer is full. The result
// is offered once it is in the buffer. Input ready drops only while the
// input register is held and the output buffer is full. Reset restores the
// PIN 1,2,3,4 and the register defaults at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module keypad_pin_alarm_controller_core #(
    parameter int PIN_DIGITS = kpac_pkg::PIN_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [kpac_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [3:0] key_code
    input  logic [kpac_pkg::S_TUSER_W-1:0]  i_s_tuser,   // [1:0] command
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] mode, [3] buzzer, [6:4] digits_entered, [9:7] attempts_left,
    // [11:10] pin_result
    output logic [kpac_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [kpac_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [kpac_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import kpac_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_vld;
    logic [1:0] r_cmd;
    logic [3:0] r_key;
    logic       accept, advance, q_full;
    t_result    eng_result, q_data;

    assign o_s_tready = !r_in_vld || !q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign advance    = r_in_vld && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_delay    <= ARM_DELAY_RST;
            r_cfg.buzzer_delay <= BUZZER_DELAY_RST;
            r_cfg.max_attempts <= MAX_ATTEMPTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ARM_DELAY:    r_cfg.arm_delay    <= i_cfg_wdata;
                CFG_BUZZER_DELAY: r_cfg.buzzer_delay <= i_cfg_wdata;
                CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_s_tuser[1:0];
            r_key <= i_s_tdata[3:0];
        end
    end

    kpac_engine #(
        .PIN_DIGITS (PIN_DIGITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_cmd    (r_cmd),
        .i_key    (r_key),
        .i_cfg    (r_cfg),
        .o_result (eng_result)
    );

    kpac_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (eng_result),
        .o_full  (q_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (q_data)
    );

    assign o_m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, q_data};

endmodule

>>> verif/keypad_pin_alarm_controller_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_pin_alarm_controller_core_test
// Self-checking bench for the keypad PIN alarm core. A behavioural model of
// the alarm predicts one result per accepted item and every result is checked
// field by field. A second copy of the model steers the random item stream so
// that arming, PIN changes, motion entry and lockout are all reached.
// ----------------------------------------------------------------------------
module keypad_pin_alarm_controller_core_test;
    import kpac_pkg::*;

    localparam int PIN_N = PIN_DIGITS_DEF;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [3:0] KEY_TOP = 4'd15;

    typedef struct packed {
        t_mode                 mode;
        logic [PIN_N-1:0][3:0] pin;
        logic [PIN_N-1:0][3:0] entered;
        logic [2:0]            count;
        logic [15:0]           ticks;
        logic [2:0]            tries;
        logic                  buzz;
        logic [15:0]           arm_dly;
        logic [15:0]           buzz_dly;
        logic [2:0]            max_att;
    } t_alarm;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] key;
    } t_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_item   key_events_q[$];
    t_result result_q[$];
    t_alarm  live_st;
    t_alarm  plan_st;
    t_item   cur_item;
    t_result seen;
    t_result wanted;
    int      pending_n = 0;
    int      errors = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      calm_s = 0;
    int      calm_m = 0;
    bit      quiet = 1'b0;
    bit      s_taken = 1'b0;
    bit      attempt_good = 1'b0;

    keypad_pin_alarm_controller_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [3:0] key_code
        .i_s_tuser   (i_s_tuser),   // [1:0] command
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        // [2:0] mode, [3] buzzer, [6:4] digits_entered, [9:7] attempts_left,
        // [11:10] pin_result
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Alarm model
    // ------------------------------------------------------------------------
    function automatic t_alarm alarm_reset();
        t_alarm st;
        st = '0;
        st.mode = MODE_DISARMED;
        for (int i = 0; i < PIN_N; i++) st.pin[i] = 4'(i + 1);
        st.arm_dly = ARM_DELAY_RST;
        st.buzz_dly = BUZZER_DELAY_RST;
        st.max_att = MAX_ATTEMPTS_RST;
        return st;
    endfunction

    // Stores one digit; true once a whole PIN has been gathered.
    function automatic bit gather_digit(inout t_alarm st, input logic [3:0] key);
        if (key > KEY_DIGIT_MAX) return 1'b0;
        if (st.count >= PIN_N) st.count = '0;
        st.entered[st.count] = key;
        st.count = st.count + 1'b1;
        if (st.count >= PIN_N) begin
            st.count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit tick_done(inout t_alarm st, input logic [15:0] dly);
        if (st.ticks < TICK_MAX) st.ticks = st.ticks + 1'b1;
        return st.ticks >= dly;
    endfunction

    function automatic t_result alarm_step(inout t_alarm st, input logic [1:0] cmd,
                                           input logic [3:0] key);
        t_result  r;
        t_pin_res res;
        res = PIN_NONE;
        case (st.mode)
            MODE_DISARMED: begin
                if (cmd == CMD_KEY && key == KEY_STAR) begin
                    st.mode = MODE_ARMING;
                    st.ticks = '0;
                end else if (cmd == CMD_KEY && key == KEY_HASH) begin
                    st.mode = MODE_OLDPIN;
                    st.count = '0;
                end
            end
            MODE_OLDPIN: begin
                if (cmd == CMD_KEY) begin
                    if (gather_digit(st, key)) begin
                        if (st.entered == st.pin) begin
                            st.mode = MODE_NEWPIN;
                            res = PIN_OK;
                        end else begin
                            st.mode = MODE_DISARMED;
                            res = PIN_BAD;
                        end
                    end
                end
            end
            MODE_NEWPIN: begin
                if (cmd == CMD_KEY) begin
                    if (gather_digit(st, key)) st.mode = MODE_CONFIRM;
                end
            end
            MODE_CONFIRM: begin
                // Any key but hash abandons the change and keeps the old PIN.
                if (cmd == CMD_KEY) begin
                    if (key == KEY_HASH) st.pin = st.entered;
                    st.mode = MODE_DISARMED;
                end
            end
            MODE_ARMING: begin
                if (cmd == CMD_TICK) begin
                    if (tick_done(st, st.arm_dly)) begin
                        st.mode = MODE_ARMED;
                        st.ticks = '0;
                    end
                end
            end
            MODE_ARMED: begin
                if (cmd == CMD_MOTION) begin
                    st.mode = MODE_ENTRY;
                    st.ticks = '0;
                    st.count = '0;
                    st.tries = (st.max_att == 3'd0) ? 3'd1 : st.max_att;
                end
            end
            MODE_ENTRY: begin
                if (cmd == CMD_KEY) begin
                    if (gather_digit(st, key)) begin
                        if (st.entered == st.pin) begin
                            st.mode = MODE_DISARMED;
                            st.buzz = 1'b0;
                            st.ticks = '0;
                            st.tries = '0;
                            res = PIN_OK;
                        end else begin
                            res = PIN_BAD;
                            if (st.tries > 3'd0) st.tries = st.tries - 1'b1;
                            if (st.tries == 3'd0) st.mode = MODE_LOCKED;
                        end
                    end
                end else if (cmd == CMD_TICK && !st.buzz) begin
                    if (tick_done(st, st.buzz_dly)) st.buzz = 1'b1;
                end
            end
            default: begin
                // Locked: the buzzer delay keeps running.
                if (cmd == CMD_TICK && !st.buzz) begin
                    if (tick_done(st, st.buzz_dly)) st.buzz = 1'b1;
                end
            end
        endcase
        r.mode = st.mode;
        r.buzzer = st.buzz;
        r.digits_entered = st.count;
        r.attempts_left = st.tries;
        r.pin_result = res;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int idle_len(inout int calm);
        int r;
        if (quiet) return 0;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic send(input logic [1:0] cmd, input logic [3:0] key);
        t_item it;
        it.cmd = cmd;
        it.key = key;
        void'(alarm_step(plan_st, cmd, key));
        key_events_q.push_back(it);
        pending_n++;
    endtask

    task automatic send_digits(input logic [15:0] d);
        for (int i = 0; i < PIN_N; i++) send(CMD_KEY, d[15 - 4 * i -: 4]);
    endtask

    // One item chosen from the planned mode; mostly well-formed, some noise.
    // Unless heading for lockout, the last remaining attempt always carries
    // the right PIN, since lockout can only be left by reset.
    task automatic send_random(input bit to_lock);
        int         r;
        logic [1:0] any_cmd;
        logic [3:0] any_key;
        logic [3:0] safe_key;
        r = $urandom_range(0, 99);
        any_cmd = 2'($urandom_range(0, 3));
        any_key = 4'($urandom_range(0, 15));
        safe_key = (any_cmd == CMD_KEY) ? 4'($urandom_range(10, 15)) : any_key;
        case (plan_st.mode)
            MODE_DISARMED: begin
                if (r < (to_lock ? 70 : 40)) send(CMD_KEY, KEY_STAR);
                else if (r < 75) send(CMD_KEY, KEY_HASH);
                else send(any_cmd, any_key);
            end
            MODE_OLDPIN, MODE_ENTRY: begin
                if (r < 65) begin
                    if (plan_st.count == 3'd0) begin
                        if (to_lock) attempt_good = 1'b0;
                        else if (plan_st.mode == MODE_ENTRY && plan_st.tries == 3'd1)
                            attempt_good = 1'b1;
                        else attempt_good = ($urandom_range(0, 99) < 65);
                    end
                    if (attempt_good) send(CMD_KEY, plan_st.pin[plan_st.count]);
                    else send(CMD_KEY, 4'($urandom_range(0, 9)));
                end else if (r < 82 && plan_st.mode == MODE_ENTRY) begin
                    send(CMD_TICK, any_key);
                end else begin
                    send(any_cmd, safe_key);
                end
            end
            MODE_NEWPIN: begin
                if (r < 70) send(CMD_KEY, 4'($urandom_range(0, 9)));
                else send(any_cmd, safe_key);
            end
            MODE_CONFIRM: begin
                if (r < 80) send(CMD_KEY, KEY_HASH);
                else send(any_cmd, any_key);
            end
            MODE_ARMING: begin
                if (r < 80) send(CMD_TICK, any_key);
                else send(any_cmd, any_key);
            end
            MODE_ARMED: begin
                if (r < 45) send(CMD_MOTION, any_key);
                else send(any_cmd, any_key);
            end
            default: begin
                if (r < 50) send(CMD_TICK, any_key);
                else send(any_cmd, any_key);
            end
        endcase
    endtask

    task automatic drain();
        do @(negedge i_clk); while (pending_n != 0 || result_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ARM_DELAY: begin
                live_st.arm_dly = val;
                plan_st.arm_dly = val;
            end
            CFG_BUZZER_DELAY: begin
                live_st.buzz_dly = val;
                plan_st.buzz_dly = val;
            end
            CFG_MAX_ATTEMPTS: begin
                live_st.max_att = val[2:0];
                plan_st.max_att = val[2:0];
            end
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] arm, input logic [15:0] buzz,
                             input logic [2:0] att);
        drain();
        write_reg(CFG_ARM_DELAY, arm);
        write_reg(CFG_BUZZER_DELAY, buzz);
        // Bits above the register width are ignored.
        write_reg(CFG_MAX_ATTEMPTS, {13'($urandom), att});
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        errors++;
        if (errors <= 40)
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    endtask

    // ------------------------------------------------------------------------
    // Item driver and result receiver, both moving at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (s_taken || !i_s_tvalid)) begin
            if (gap_left > 0 || key_events_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_s_tvalid <= 1'b0;
            end else begin
                cur_item = key_events_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {{(S_TDATA_W - 4){1'b0}}, cur_item.key};
                i_s_tuser <= cur_item.cmd;
                gap_left = idle_len(calm_s);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            stall_left = idle_len(calm_m);
        end
    end

    always @(posedge i_clk) begin
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                result_q.push_back(alarm_step(live_st, i_s_tuser, i_s_tdata[3:0]));
                pending_n--;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    flag_mismatch("result with no item outstanding", o_m_tdata, '0);
                end else begin
                    wanted = result_q.pop_front();
                    seen = o_m_tdata[RESULT_W-1:0];
                    if (seen.mode !== wanted.mode)
                        flag_mismatch("mode", seen.mode, wanted.mode);
                    if (seen.buzzer !== wanted.buzzer)
                        flag_mismatch("buzzer", seen.buzzer, wanted.buzzer);
                    if (seen.digits_entered !== wanted.digits_entered)
                        flag_mismatch("digits_entered", seen.digits_entered,
                                      wanted.digits_entered);
                    if (seen.attempts_left !== wanted.attempts_left)
                        flag_mismatch("attempts_left", seen.attempts_left,
                                      wanted.attempts_left);
                    if (seen.pin_result !== wanted.pin_result)
                        flag_mismatch("pin_result", seen.pin_result, wanted.pin_result);
                    if (o_m_tdata[M_TDATA_W-1:RESULT_W] !== '0)
                        flag_mismatch("tdata padding", o_m_tdata, '0);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        live_st = alarm_reset();
        plan_st = live_st;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ignored events, wrong and right old PIN, abandoned change.
        send(CMD_KEY, 4'd5);
        send(CMD_TICK, 4'd0);
        send(CMD_MOTION, 4'd9);
        send(CMD_SPARE, KEY_TOP);
        send(CMD_KEY, KEY_HASH);
        send_digits(16'h9090);
        send(CMD_KEY, KEY_HASH);
        send(CMD_KEY, KEY_STAR);
        send_digits(16'h1234);
        send_digits(16'h8765);
        send(CMD_KEY, 4'd0);

        // Zero delays complete on the first tick; zero attempts behave as one.
        configure(16'd0, 16'd0, 3'd0);
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        send(CMD_KEY, KEY_STAR);
        send(CMD_TICK, 4'd3);
        send(CMD_MOTION, 4'd0);
        send(CMD_TICK, 4'd6);
        send_digits(16'h1234);

        // Longer delays, run back to back without idling.
        configure(16'd40, 16'd30, 3'd7);
        quiet = 1'b1;
        send(CMD_KEY, KEY_STAR);
        repeat (40) send(CMD_TICK, 4'($urandom_range(0, 15)));
        send(CMD_MOTION, 4'd0);
        repeat (40) send(CMD_TICK, 4'($urandom_range(0, 15)));
        drain();
        quiet = 1'b0;
        send_digits(16'h0000);
        send_digits(16'h1234);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(16'd1, 16'd1, 3'd1);
                1: configure(16'd4, 16'd9, 3'd7);
                2: configure(16'd1, 16'd3, 3'd2);
                default: configure(16'($urandom_range(1, 16)), 16'($urandom_range(1, 24)),
                                   3'($urandom_range(1, 7)));
            endcase
            repeat (140) send_random(1'b0);
            // Hold the sender until the block has answered everything.
            drain();
            repeat (140) send_random(1'b0);
        end

        // Lockout ends the run, as only reset leaves it.
        configure(16'd2, 16'd12, 3'd2);
        for (int n = 0; n < 600 && plan_st.mode != MODE_LOCKED; n++) send_random(1'b1);
        repeat (60) send_random(1'b1);

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #25000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
